[hdl/sm4_pkg.sv]
`timescale 1ns / 1ps

package sm4_pkg;

  // Cipher geometry
  localparam int ROUNDS  = 32;
  localparam int RK_AW   = $clog2(ROUNDS);

  typedef logic [31:0]       word_t;
  typedef logic [3:0][31:0]  block_t;   // word 0 at index 0
  typedef logic [RK_AW-1:0]  rk_addr_t;

  // Round key store access, one write and one read port
  typedef struct packed {
    logic     we;
    rk_addr_t waddr;
    word_t    wdata;
    rk_addr_t raddr;
  } rk_req_t;

  // System parameter FK
  localparam word_t FK [4] = '{32'ha3b1bac6, 32'h56aa3350, 32'h677d9197, 32'hb27022dc};

  localparam logic [7:0] SBOX [256] = '{
    8'hd6, 8'h90, 8'he9, 8'hfe, 8'hcc, 8'he1, 8'h3d, 8'hb7,
    8'h16, 8'hb6, 8'h14, 8'hc2, 8'h28, 8'hfb, 8'h2c, 8'h05,
    8'h2b, 8'h67, 8'h9a, 8'h76, 8'h2a, 8'hbe, 8'h04, 8'hc3,
    8'haa, 8'h44, 8'h13, 8'h26, 8'h49, 8'h86, 8'h06, 8'h99,
    8'h9c, 8'h42, 8'h50, 8'hf4, 8'h91, 8'hef, 8'h98, 8'h7a,
    8'h33, 8'h54, 8'h0b, 8'h43, 8'hed, 8'hcf, 8'hac, 8'h62,
    8'he4, 8'hb3, 8'h1c, 8'ha9, 8'hc9, 8'h08, 8'he8, 8'h95,
    8'h80, 8'hdf, 8'h94, 8'hfa, 8'h75, 8'h8f, 8'h3f, 8'ha6,
    8'h47, 8'h07, 8'ha7, 8'hfc, 8'hf3, 8'h73, 8'h17, 8'hba,
    8'h83, 8'h59, 8'h3c, 8'h19, 8'he6, 8'h85, 8'h4f, 8'ha8,
    8'h68, 8'h6b, 8'h81, 8'hb2, 8'h71, 8'h64, 8'hda, 8'h8b,
    8'hf8, 8'heb, 8'h0f, 8'h4b, 8'h70, 8'h56, 8'h9d, 8'h35,
    8'h1e, 8'h24, 8'h0e, 8'h5e, 8'h63, 8'h58, 8'hd1, 8'ha2,
    8'h25, 8'h22, 8'h7c, 8'h3b, 8'h01, 8'h21, 8'h78, 8'h87,
    8'hd4, 8'h00, 8'h46, 8'h57, 8'h9f, 8'hd3, 8'h27, 8'h52,
    8'h4c, 8'h36, 8'h02, 8'he7, 8'ha0, 8'hc4, 8'hc8, 8'h9e,
    8'hea, 8'hbf, 8'h8a, 8'hd2, 8'h40, 8'hc7, 8'h38, 8'hb5,
    8'ha3, 8'hf7, 8'hf2, 8'hce, 8'hf9, 8'h61, 8'h15, 8'ha1,
    8'he0, 8'hae, 8'h5d, 8'ha4, 8'h9b, 8'h34, 8'h1a, 8'h55,
    8'had, 8'h93, 8'h32, 8'h30, 8'hf5, 8'h8c, 8'hb1, 8'he3,
    8'h1d, 8'hf6, 8'he2, 8'h2e, 8'h82, 8'h66, 8'hca, 8'h60,
    8'hc0, 8'h29, 8'h23, 8'hab, 8'h0d, 8'h53, 8'h4e, 8'h6f,
    8'hd5, 8'hdb, 8'h37, 8'h45, 8'hde, 8'hfd, 8'h8e, 8'h2f,
    8'h03, 8'hff, 8'h6a, 8'h72, 8'h6d, 8'h6c, 8'h5b, 8'h51,
    8'h8d, 8'h1b, 8'haf, 8'h92, 8'hbb, 8'hdd, 8'hbc, 8'h7f,
    8'h11, 8'hd9, 8'h5c, 8'h41, 8'h1f, 8'h10, 8'h5a, 8'hd8,
    8'h0a, 8'hc1, 8'h31, 8'h88, 8'ha5, 8'hcd, 8'h7b, 8'hbd,
    8'h2d, 8'h74, 8'hd0, 8'h12, 8'hb8, 8'he5, 8'hb4, 8'hb0,
    8'h89, 8'h69, 8'h97, 8'h4a, 8'h0c, 8'h96, 8'h77, 8'h7e,
    8'h65, 8'hb9, 8'hf1, 8'h09, 8'hc5, 8'h6e, 8'hc6, 8'h84,
    8'h18, 8'hf0, 8'h7d, 8'hec, 8'h3a, 8'hdc, 8'h4d, 8'h20,
    8'h79, 8'hee, 8'h5f, 8'h3e, 8'hd7, 8'hcb, 8'h39, 8'h48
  };

  function automatic word_t rotl(input word_t x, input int n);
    rotl = (x << n) | (x >> (32 - n));
  endfunction

  // Byte-wise S-box substitution
  function automatic word_t sub_word(input word_t w);
    sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  // Linear layer of the data rounds
  function automatic word_t lin_data(input word_t b);
    lin_data = b ^ rotl(b, 2) ^ rotl(b, 10) ^ rotl(b, 18) ^ rotl(b, 24);
  endfunction

  // Linear layer of the key schedule
  function automatic word_t lin_key(input word_t b);
    lin_key = b ^ rotl(b, 13) ^ rotl(b, 23);
  endfunction

  // CK[i]: byte j, most significant first, is (4i + j) * 7 mod 256
  function automatic word_t ck_word(input rk_addr_t i);
    logic [7:0] base;
    word_t      r;
    base = {1'b0, i, 2'b00};
    r    = '0;
    for (int j = 0; j < 4; j++) begin
      r = {r[23:0], 8'((base + 8'(j)) * 8'd7)};
    end
    ck_word = r;
  endfunction

endpackage

[hdl/sm4_round.sv]
`timescale 1ns / 1ps

// Shared SM4 round: nw = w0 ^ T(w1 ^ w2 ^ w3 ^ rk), T with the data or key linear layer
module sm4_round (
  input  sm4_pkg::block_t words,
  input  sm4_pkg::word_t  rk,
  input  logic            key_mode,
  output sm4_pkg::word_t  nw
);
  import sm4_pkg::*;

  word_t mix;
  word_t sub;

  assign mix = words[1] ^ words[2] ^ words[3] ^ rk;
  assign sub = sub_word(mix);
  assign nw  = words[0] ^ (key_mode ? lin_key(sub) : lin_data(sub));

endmodule

[hdl/sm4_rk_store.sv]
`timescale 1ns / 1ps

// Round key memory: one write port, one registered read port
module sm4_rk_store (
  input  logic             clk,
  input  sm4_pkg::rk_req_t req,
  output sm4_pkg::word_t   rdata
);
  import sm4_pkg::*;

  word_t mem [ROUNDS];
  word_t rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata_r <= mem[req.raddr];
  end

  assign rdata = rdata_r;

endmodule

[hdl/sm4_block_cipher.sv]
`timescale 1ns / 1ps

// SM4 block cipher, 128-bit block and key.
// Key: four 32-bit words written on the cfg port (index 0..3, word 0 first).
//   Any key write marks the round keys stale; write only while the block is idle.
// Input beat: in_tdata holds the block, word 0 in the low bits; in_tuser is
//   the opcode (0 encrypt, 1 decrypt).
// Output beat: out_tdata holds the result block, word 0 in the low bits.
// Sequence: in_tready is high only while the sequencer is idle. After a beat,
//   a stale key is first expanded, one round key per cycle. Then the prep
//   state fetches the first round key and the shared round unit runs the
//   32 rounds, one per cycle, reading the round key memory. The result is
//   loaded into the output register from the final state once that register
//   is free; a new block is taken only after the last one has been loaded.
// Stall: the output register holds its beat until out_tready. The next block
//   may be taken and processed meanwhile; it waits in its last step until the
//   output register is free.
// Reset: rst_n (synchronous, active low) clears the key to zero, marks the
//   round keys stale and drops out_tvalid.
module sm4_block_cipher (
  input  logic         clk,
  input  logic         rst_n,
  // config write port
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_wdata,
  // input stream
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,   // in_word_0, in_word_1, in_word_2, in_word_3
  input  logic         in_tuser,   // opcode
  // output stream
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata   // out_word_0, out_word_1, out_word_2, out_word_3
);
  import sm4_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_KEXP  = 3'd1;
  localparam logic [2:0] S_PREP  = 3'd2;
  localparam logic [2:0] S_CRYPT = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  localparam rk_addr_t LAST = rk_addr_t'(ROUNDS - 1);

  logic [2:0]  state_r, state_nxt;
  rk_addr_t    cnt_r, cnt_nxt;
  logic        keys_ready_r;
  logic        dec_r;
  word_t       key_word_r [4];
  block_t      k_r;
  block_t      x_r;
  logic        out_valid_r;
  logic [127:0] out_data_r;

  logic        in_beat;
  logic        out_free;
  block_t      rnd_words;
  word_t       rnd_key;
  word_t       rnd_nw;
  word_t       rk_rdata;
  rk_addr_t    rd_round;
  rk_req_t     rk_req;

  assign in_tready = (state_r == S_IDLE);
  assign in_beat   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  // Shared round unit: key schedule or data round
  always_comb begin
    if (state_r == S_KEXP) begin
      rnd_words = k_r;
      rnd_key   = ck_word(cnt_r);
    end else begin
      rnd_words = x_r;
      rnd_key   = rk_rdata;
    end
  end

  sm4_round u_round (
    .words    (rnd_words),
    .rk       (rnd_key),
    .key_mode (state_r == S_KEXP),
    .nw       (rnd_nw)
  );

  // Round key memory access; read runs one round ahead of the data path
  assign rd_round = (state_r == S_PREP) ? '0 : cnt_r + 1'b1;

  always_comb begin
    rk_req.we    = (state_r == S_KEXP);
    rk_req.waddr = cnt_r;
    rk_req.wdata = rnd_nw;
    rk_req.raddr = dec_r ? LAST - rd_round : rd_round;
  end

  sm4_rk_store u_store (
    .clk   (clk),
    .req   (rk_req),
    .rdata (rk_rdata)
  );

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      S_IDLE: begin
        cnt_nxt = '0;
        if (in_beat) begin
          state_nxt = keys_ready_r ? S_PREP : S_KEXP;
        end
      end
      S_KEXP: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == LAST) begin
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        cnt_nxt   = '0;
        state_nxt = S_CRYPT;
      end
      S_CRYPT: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == LAST) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cnt_r        <= '0;
      keys_ready_r <= 1'b0;
      out_valid_r  <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        key_word_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (cfg_we) begin
        key_word_r[cfg_index] <= cfg_wdata;
        keys_ready_r          <= 1'b0;
      end else if (state_r == S_KEXP && cnt_r == LAST) begin
        keys_ready_r <= 1'b1;
      end
      if (state_r == S_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (in_beat) begin
      dec_r <= in_tuser;
      for (int i = 0; i < 4; i++) begin
        x_r[i] <= in_tdata[32*i +: 32];
        k_r[i] <= key_word_r[i] ^ FK[i];
      end
    end else if (state_r == S_KEXP) begin
      k_r <= {rnd_nw, k_r[3], k_r[2], k_r[1]};
    end else if (state_r == S_CRYPT) begin
      x_r <= {rnd_nw, x_r[3], x_r[2], x_r[1]};
    end
    // final words reversed: word 3 goes out as word 0
    if (state_r == S_FIN && out_free) begin
      out_data_r <= {x_r[0], x_r[1], x_r[2], x_r[3]};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

import sm4_pkg::word_t;
import sm4_pkg::block_t;
import sm4_pkg::ROUNDS;

typedef enum logic {
  OP_ENCRYPT = 1'b0,
  OP_DECRYPT = 1'b1
} sm4_op_e;

localparam int KEY_WORDS = 4;

// S-box, entry 0 in the leftmost byte
localparam logic [0:255][7:0] SM4_SBOX = {
  128'hd690e9fecce13db716b614c228fb2c05, 128'h2b679a762abe04c3aa44132649860699,
  128'h9c4250f491ef987a33540b43edcfac62, 128'he4b31ca9c908e89580df94fa758f3fa6,
  128'h4707a7fcf37317ba83593c19e6854fa8, 128'h686b81b27164da8bf8eb0f4b70569d35,
  128'h1e240e5e6358d1a225227c3b01217887, 128'hd40046579fd327524c3602e7a0c4c89e,
  128'heabf8ad240c738b5a3f7f2cef96115a1, 128'he0ae5da49b341a55ad933230f58cb1e3,
  128'h1df6e22e8266ca60c02923ab0d534e6f, 128'hd5db3745defd8e2f03ff6a726d6c5b51,
  128'h8d1baf92bbddbc7f11d95c411f105ad8, 128'h0ac13188a5cd7bbd2d74d012b8e5b4b0,
  128'h8969974a0c96777e65b9f109c56ec684, 128'h18f07dec3adc4d2079ee5f3ed7cb3948
};

localparam word_t SM4_FK [KEY_WORDS] = '{
  32'ha3b1bac6, 32'h56aa3350, 32'h677d9197, 32'hb27022dc
};

// Tracks the key, expands it on demand and holds the ciphertext
// (or plaintext) each accepted block must produce.
class sm4_cipher_checker;
  word_t  key_regs [KEY_WORDS];
  word_t  round_keys [ROUNDS];
  bit     keys_valid;
  block_t expected_blocks [$];
  int     mismatches;

  function new();
    foreach (key_regs[i]) key_regs[i] = '0;
    keys_valid = 1'b0;
    mismatches = 0;
  endfunction

  function word_t rol(word_t x, int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function word_t subst(word_t w);
    return {SM4_SBOX[w[31:24]], SM4_SBOX[w[23:16]], SM4_SBOX[w[15:8]], SM4_SBOX[w[7:0]]};
  endfunction

  function word_t key_mix(word_t w);
    word_t b;
    b = subst(w);
    return b ^ rol(b, 13) ^ rol(b, 23);
  endfunction

  function word_t round_mix(word_t w);
    word_t b;
    b = subst(w);
    return b ^ rol(b, 2) ^ rol(b, 10) ^ rol(b, 18) ^ rol(b, 24);
  endfunction

  // CK: byte j, most significant first, is (4i + j) * 7 mod 256
  function word_t ck_const(int i);
    word_t r;
    r = '0;
    for (int j = 0; j < 4; j++) r = (r << 8) | word_t'(((4 * i + j) * 7) & 8'hff);
    return r;
  endfunction

  function void expand_key();
    word_t k [KEY_WORDS];
    word_t nk;
    for (int i = 0; i < KEY_WORDS; i++) k[i] = key_regs[i] ^ SM4_FK[i];
    for (int i = 0; i < ROUNDS; i++) begin
      nk = k[0] ^ key_mix(k[1] ^ k[2] ^ k[3] ^ ck_const(i));
      round_keys[i] = nk;
      k[0] = k[1];
      k[1] = k[2];
      k[2] = k[3];
      k[3] = nk;
    end
    keys_valid = 1'b1;
  endfunction

  function block_t cipher_block(bit decrypt, block_t data);
    word_t  x [4];
    word_t  rk;
    word_t  nx;
    block_t res;
    for (int i = 0; i < 4; i++) x[i] = data[i];
    for (int r = 0; r < ROUNDS; r++) begin
      rk = decrypt ? round_keys[ROUNDS - 1 - r] : round_keys[r];
      nx = x[0] ^ round_mix(x[1] ^ x[2] ^ x[3] ^ rk);
      x[0] = x[1];
      x[1] = x[2];
      x[2] = x[3];
      x[3] = nx;
    end
    for (int i = 0; i < 4; i++) res[i] = x[3 - i];
    return res;
  endfunction

  // any key write makes the round keys stale
  function void write_key(int idx, word_t value);
    if (idx < KEY_WORDS) begin
      key_regs[idx] = value;
      keys_valid = 1'b0;
    end
  endfunction

  function void note_block(bit decrypt, block_t data);
    if (!keys_valid) expand_key();
    expected_blocks.push_back(cipher_block(decrypt, data));
  endfunction

  function void check_block(block_t got);
    block_t exp;
    if (expected_blocks.size() == 0) begin
      $display("%0t: output beat %032h with no block pending", $time, got);
      mismatches++;
      return;
    end
    exp = expected_blocks.pop_front();
    for (int i = 0; i < 4; i++) begin
      if (got[i] !== exp[i]) begin
        $display("%0t: out_word_%0d expected %08h actual %08h", $time, i, exp[i], got[i]);
        mismatches++;
      end
    end
  endfunction

  function int pending_count();
    return expected_blocks.size();
  endfunction
endclass

module testbench;

  localparam int CYCLE_LIMIT  = 1_200_000;
  localparam int RANDOM_ITEMS = 1150;
  localparam int DRAIN_CYCLES = 80;

  logic         clk;
  logic         rst_n;
  logic         cfg_we;
  logic [1:0]   cfg_index;
  logic [31:0]  cfg_wdata;
  logic         in_tvalid;
  logic         in_tready;
  logic [127:0] in_tdata;   // in_word_0, in_word_1, in_word_2, in_word_3
  logic         in_tuser;   // opcode
  logic         out_tvalid;
  logic         out_tready;
  logic [127:0] out_tdata;  // out_word_0, out_word_1, out_word_2, out_word_3

  sm4_cipher_checker chk;
  bit steady;
  int stall_left;
  int cycle_count;

  sm4_block_cipher uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // timeout
  initial begin
    cycle_count = 0;
    wait (cycle_count >= CYCLE_LIMIT);
    $display("sm4_block_cipher: mismatch");
    $finish;
  end

  // idle length: mostly short, some medium, a few long
  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 4);
    if (r < 93) return $urandom_range(5, 40);
    return $urandom_range(41, 80);
  endfunction

  function automatic int input_gap();
    if (steady || $urandom_range(0, 1) == 0) return 0;
    return idle_length();
  endfunction

  function automatic word_t random_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic block_t random_block();
    block_t b;
    for (int i = 0; i < 4; i++) b[i] = random_word();
    return b;
  endfunction

  function automatic block_t make_block(word_t w0, word_t w1, word_t w2, word_t w3);
    return {w3, w2, w1, w0};
  endfunction

  // result side backpressure
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_tready <= 1'b0;
    end else if (!steady && $urandom_range(0, 3) == 0) begin
      stall_left = idle_length() - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // observe config writes and both streams at the clock edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) chk.write_key(int'(cfg_index), cfg_wdata);
      if (in_tvalid && in_tready) chk.note_block(in_tuser == OP_DECRYPT, in_tdata);
      if (out_tvalid && out_tready) chk.check_block(out_tdata);
    end
  end

  // one input beat; tvalid stays high if the next beat follows at once
  task automatic send_block(input sm4_op_e op, input block_t data);
    int gap;
    gap = input_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= data;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // stop the stream and wait for every pending block to come out;
  // first wait for an edge so the last accepted beat is already noted
  task automatic finish_phase();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (chk.pending_count() != 0) @(posedge clk);
  endtask

  // write the key words selected by mask, back to back
  task automatic load_key(input block_t key, input logic [3:0] mask);
    for (int i = 0; i < KEY_WORDS; i++) begin
      if (mask[i]) begin
        cfg_we    <= 1'b1;
        cfg_index <= 2'(i);
        cfg_wdata <= key[i];
        @(posedge clk);
      end
    end
    cfg_we <= 1'b0;
  endtask

  initial begin
    block_t  key;
    block_t  std_vec;
    int      sent;
    int      n;
    sm4_op_e op;

    chk        = new();
    steady     = 1'b0;
    stall_left = 0;
    sent       = 0;
    rst_n      <= 1'b0;
    cfg_we     <= 1'b0;
    cfg_index  <= '0;
    cfg_wdata  <= '0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tuser   <= OP_ENCRYPT;
    out_tready <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset key (all zero), never written: first block expands it
    send_block(OP_ENCRYPT, '0);
    send_block(OP_DECRYPT, '0);
    send_block(OP_ENCRYPT, '1);
    send_block(OP_DECRYPT, '1);
    send_block(OP_ENCRYPT, {4{32'h80000000}});
    send_block(OP_ENCRYPT, {4{32'h00000001}});
    send_block(OP_ENCRYPT, make_block(32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa, 32'h55555555));
    send_block(OP_DECRYPT, make_block(32'h55555555, 32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa));

    // all-ones key
    finish_phase();
    load_key('1, 4'hf);
    send_block(OP_ENCRYPT, '0);
    send_block(OP_DECRYPT, '1);
    send_block(OP_ENCRYPT, '1);

    // standard vector: key equals plaintext
    finish_phase();
    std_vec = make_block(32'h01234567, 32'h89abcdef, 32'hfedcba98, 32'h76543210);
    load_key(std_vec, 4'hf);
    send_block(OP_ENCRYPT, std_vec);
    send_block(OP_DECRYPT, make_block(32'h681edf34, 32'hd206965e, 32'h86b3e94f, 32'h536e4246));
    send_block(OP_DECRYPT, std_vec);

    // single word rewrite, then zero key written explicitly
    finish_phase();
    load_key(make_block(32'h80000000, 32'h0, 32'h0, 32'h0), 4'h1);
    send_block(OP_ENCRYPT, std_vec);
    send_block(OP_DECRYPT, std_vec);
    finish_phase();
    load_key('0, 4'hf);
    send_block(OP_ENCRYPT, '0);
    send_block(OP_DECRYPT, {4{32'h00000001}});

    // random phases: new key words, random blocks
    while (sent < RANDOM_ITEMS) begin
      finish_phase();
      key = random_block();
      load_key(key, 4'($urandom_range(1, 15)));
      steady = ($urandom_range(0, 4) == 0);
      n = $urandom_range(10, 60);
      repeat (n) begin
        op = sm4_op_e'($urandom_range(0, 1));
        send_block(op, random_block());
        sent++;
      end
    end
    steady = 1'b0;

    finish_phase();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (chk.mismatches == 0 && chk.pending_count() == 0) begin
      $display("sm4_block_cipher: match");
    end else begin
      $display("sm4_block_cipher: mismatch");
    end
    $finish;
  end

endmodule

[files.f]
hdl/sm4_pkg.sv
hdl/sm4_round.sv
hdl/sm4_rk_store.sv
hdl/sm4_block_cipher.sv
tb/testbench.sv
